>>> hw/rtl/gaps_pkg.sv
// ============================================================================
// gaps_pkg
// Shared types, constants and helpers of the grid A* path search unit.
// ============================================================================
package gaps_pkg;

    localparam int MAX_WIDTH      = 64;
    localparam int MAX_HEIGHT     = 64;
    localparam int HEAP_DEPTH_DEF = 16384;

    localparam int COORD_W = 6;
    localparam int CELL_W  = 2 * COORD_W;
    localparam int CELLS   = MAX_WIDTH * MAX_HEIGHT;
    localparam int LEN_W   = CELL_W + 1;
    localparam int G_W     = 20;
    localparam int F_W     = G_W + 1;
    localparam int KEY_W   = F_W + CELL_W;
    localparam int DIM_W   = 7;
    localparam int COST_W  = 8;
    localparam int MAN_W   = COORD_W + 1;

    // command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_FIND  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOPATH = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_BEYOND = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_OPEN   = 2'd2;
    localparam logic [1:0] CFG_WALL   = 2'd3;

    // move directions: z+1, z-1, x+1, x-1
    localparam logic [1:0] DIR_ZP = 2'd0;
    localparam logic [1:0] DIR_ZN = 2'd1;
    localparam logic [1:0] DIR_XP = 2'd2;
    localparam logic [1:0] DIR_XN = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ez;
        logic [1:0]         kind;
        logic [CELL_W-1:0]  idx;
        logic               start_ok;
        logic               end_ok;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [COST_W-1:0]  open_cost;
        logic [COST_W-1:0]  wall_cost;
    } gaps_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [LEN_W-1:0]   len;
        logic [G_W-1:0]     cost;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sz;
    } gaps_res_t;

    typedef struct packed {
        logic             clear;
        logic             push;
        logic             pop;
        logic [KEY_W-1:0] key;
    } gaps_heap_req_t;

    typedef struct packed {
        logic             idle;
        logic             empty;
        logic [KEY_W-1:0] top_key;
    } gaps_heap_sts_t;

    typedef struct packed {
        logic           seen;
        logic           closed;
        logic [1:0]     dir;
        logic [G_W-1:0] g;
    } gaps_node_t;

    function automatic logic [MAN_W-1:0] manhattan(
        input logic [COORD_W-1:0] x0, input logic [COORD_W-1:0] z0,
        input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] z1);
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dz;
        dx = (x0 >= x1) ? (x0 - x1) : (x1 - x0);
        dz = (z0 >= z1) ? (z0 - z1) : (z1 - z0);
        return MAN_W'(dx) + MAN_W'(dz);
    endfunction

endpackage

>>> hw/rtl/gaps_heap.sv
// ============================================================================
// gaps_heap
// Binary min-heap of search keys in one dual-read synchronous memory.
// ============================================================================
module gaps_heap #(
    parameter int HEAP_DEPTH = gaps_pkg::HEAP_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  gaps_pkg::gaps_heap_req_t req,
    output gaps_pkg::gaps_heap_sts_t sts
);
    import gaps_pkg::*;

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = AW + 1;
    localparam int IW = AW + 2;
    localparam logic [CW-1:0] FULL = CW'(HEAP_DEPTH);

    localparam logic [2:0] H_IDLE     = 3'd0;
    localparam logic [2:0] H_PUSH_RD  = 3'd1;
    localparam logic [2:0] H_PUSH_CMP = 3'd2;
    localparam logic [2:0] H_POP_LAST = 3'd3;
    localparam logic [2:0] H_SIFT_RD  = 3'd4;
    localparam logic [2:0] H_SIFT_CMP = 3'd5;

    logic [KEY_W-1:0] mem [HEAP_DEPTH];
    logic [KEY_W-1:0] rd0_reg, rd1_reg;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [IW-1:0]    pos_reg, pos_next;
    logic [IW-1:0]    child_reg, child_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [KEY_W-1:0] top_reg, top_next;

    logic             we;
    logic [AW-1:0]    wa, ra0, ra1;
    logic [KEY_W-1:0] wd;

    logic [IW-1:0]    parent, first_child, count_x;
    logic             take_right;
    logic [KEY_W-1:0] child_val;

    assign count_x     = IW'(count_reg);
    assign parent      = (pos_reg - IW'(1)) >> 1;
    assign first_child = {pos_reg[IW-2:0], 1'b1};
    assign take_right  = ((child_reg + IW'(1)) < count_x) && (rd1_reg < rd0_reg);
    assign child_val   = take_right ? rd1_reg : rd0_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        child_next = child_reg;
        key_next   = key_reg;
        top_next   = top_reg;
        we         = 1'b0;
        wa         = pos_reg[AW-1:0];
        wd         = key_reg;
        ra0        = parent[AW-1:0];
        ra1        = first_child[AW-1:0] + AW'(1);
        case (state_reg)
            H_IDLE: begin
                if (req.clear) begin
                    count_next = '0;
                end else if (req.push) begin
                    // a push into a full heap is dropped
                    if (count_reg != FULL) begin
                        count_next = count_reg + CW'(1);
                        pos_next   = count_x;
                        key_next   = req.key;
                        state_next = H_PUSH_RD;
                    end
                end else if (req.pop) begin
                    count_next = count_reg - CW'(1);
                    ra0        = '0;
                    ra1        = AW'(count_reg - CW'(1));
                    state_next = H_POP_LAST;
                end
            end
            H_PUSH_RD: begin
                if (pos_reg == '0) begin
                    we         = 1'b1;
                    state_next = H_IDLE;
                end else begin
                    ra0        = parent[AW-1:0];
                    state_next = H_PUSH_CMP;
                end
            end
            H_PUSH_CMP: begin
                we = 1'b1;
                if (rd0_reg <= key_reg) begin
                    state_next = H_IDLE;
                end else begin
                    wd         = rd0_reg;
                    pos_next   = parent;
                    state_next = H_PUSH_RD;
                end
            end
            H_POP_LAST: begin
                top_next   = rd0_reg;
                key_next   = rd1_reg;
                pos_next   = '0;
                state_next = H_SIFT_RD;
            end
            H_SIFT_RD: begin
                if (first_child >= count_x) begin
                    we         = (count_reg != '0);
                    state_next = H_IDLE;
                end else begin
                    ra0        = first_child[AW-1:0];
                    child_next = first_child;
                    state_next = H_SIFT_CMP;
                end
            end
            H_SIFT_CMP: begin
                we = 1'b1;
                if (key_reg <= child_val) begin
                    state_next = H_IDLE;
                end else begin
                    wd         = child_val;
                    pos_next   = child_reg + IW'(take_right);
                    state_next = H_SIFT_RD;
                end
            end
            default: state_next = H_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        pos_reg   <= pos_next;
        child_reg <= child_next;
        key_reg   <= key_next;
        top_reg   <= top_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd0_reg <= mem[ra0];
        rd1_reg <= mem[ra1];
    end

    assign sts.idle    = (state_reg == H_IDLE);
    assign sts.empty   = (count_reg == '0);
    assign sts.top_key = top_reg;

endmodule

>>> hw/rtl/gaps_search.sv
// ============================================================================
// gaps_search
// Command sequencer: grid, node and path memories, A* loop and path trace.
// ============================================================================
module gaps_search (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  gaps_pkg::gaps_req_t      req,
    input  logic                     req_valid,
    output logic                     req_ready,
    output gaps_pkg::gaps_res_t      res,
    output logic                     res_valid,
    input  logic                     res_ready,
    output gaps_pkg::gaps_heap_req_t heap_req,
    input  gaps_pkg::gaps_heap_sts_t heap_sts
);
    import gaps_pkg::*;

    localparam logic [3:0] S_INIT      = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_READ      = 4'd2;
    localparam logic [3:0] S_CLR       = 4'd3;
    localparam logic [3:0] S_SEED      = 4'd4;
    localparam logic [3:0] S_POP       = 4'd5;
    localparam logic [3:0] S_POP_WAIT  = 4'd6;
    localparam logic [3:0] S_CHK       = 4'd7;
    localparam logic [3:0] S_NB        = 4'd8;
    localparam logic [3:0] S_NB_CHK    = 4'd9;
    localparam logic [3:0] S_PUSH_WAIT = 4'd10;
    localparam logic [3:0] S_TR        = 4'd11;
    localparam logic [3:0] S_TR_RD     = 4'd12;
    localparam logic [3:0] S_DONE      = 4'd13;

    // memories
    logic              grid_mem [CELLS];
    gaps_node_t        node_mem [CELLS];
    logic [CELL_W-1:0] path_mem [CELLS];
    logic              grid_rd;
    gaps_node_t        node_rd;
    logic [CELL_W-1:0] path_rd;

    logic              grid_we, grid_wd, node_we, path_we;
    logic [CELL_W-1:0] grid_wa, grid_ra, node_wa, node_ra, path_wa, path_ra;
    gaps_node_t        node_wd;

    logic [3:0]        state_reg, state_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    gaps_req_t         r_reg, r_next;
    gaps_res_t         res_reg, res_next;
    logic [LEN_W-1:0]  slen_reg, slen_next;
    logic [G_W-1:0]    scost_reg, scost_next;
    logic [CELL_W-1:0] cur_reg, cur_next;
    logic [CELL_W-1:0] nb_reg, nb_next;
    logic [G_W-1:0]    gcur_reg, gcur_next;
    logic [1:0]        dir_reg, dir_next;

    logic [COORD_W-1:0] cx, cz, nx, nz, px, pz;
    logic               nb_ok;
    logic [CELL_W-1:0]  start_cell, end_cell;
    logic [G_W-1:0]     ng;
    logic [F_W-1:0]     nf;

    assign cx         = cur_reg[COORD_W-1:0];
    assign cz         = cur_reg[CELL_W-1:COORD_W];
    assign start_cell = {r_reg.z, r_reg.x};
    assign end_cell   = {r_reg.ez, r_reg.ex};
    assign ng         = gcur_reg + G_W'(grid_rd ? r_reg.wall_cost : r_reg.open_cost);
    assign nf         = F_W'(ng)
                      + F_W'(manhattan(nb_reg[COORD_W-1:0], nb_reg[CELL_W-1:COORD_W],
                                       r_reg.ex, r_reg.ez));

    // neighbor of the current cell in direction dir_reg
    always_comb begin
        nx    = cx;
        nz    = cz;
        nb_ok = 1'b0;
        case (dir_reg)
            DIR_ZP: begin
                nz    = cz + COORD_W'(1);
                nb_ok = (DIM_W'(cz) + DIM_W'(1)) < r_reg.h;
            end
            DIR_ZN: begin
                nz    = cz - COORD_W'(1);
                nb_ok = (cz != '0);
            end
            DIR_XP: begin
                nx    = cx + COORD_W'(1);
                nb_ok = (DIM_W'(cx) + DIM_W'(1)) < r_reg.w;
            end
            DIR_XN: begin
                nx    = cx - COORD_W'(1);
                nb_ok = (cx != '0);
            end
            default: nb_ok = 1'b0;
        endcase
    end

    // step back against the stored move direction
    always_comb begin
        px = cx;
        pz = cz;
        case (node_rd.dir)
            DIR_ZP:  pz = cz - COORD_W'(1);
            DIR_ZN:  pz = cz + COORD_W'(1);
            DIR_XP:  px = cx - COORD_W'(1);
            DIR_XN:  px = cx + COORD_W'(1);
            default: px = cx;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        r_next     = r_reg;
        res_next   = res_reg;
        slen_next  = slen_reg;
        scost_next = scost_reg;
        cur_next   = cur_reg;
        nb_next    = nb_reg;
        gcur_next  = gcur_reg;
        dir_next   = dir_reg;
        grid_we    = 1'b0;
        grid_wa    = {req.z, req.x};
        grid_wd    = req.kind[1];
        grid_ra    = {nz, nx};
        node_we    = 1'b0;
        node_wa    = cur_reg;
        node_wd    = node_rd;
        node_ra    = {nz, nx};
        path_we    = 1'b0;
        path_wa    = cnt_reg[CELL_W-1:0];
        path_ra    = CELL_W'(slen_reg - LEN_W'(req.idx) - LEN_W'(1));
        heap_req   = '0;
        heap_req.key = {nf, nb_reg};

        case (state_reg)
            S_INIT: begin
                // clear the grid after reset
                grid_we  = 1'b1;
                grid_wa  = cnt_reg[CELL_W-1:0];
                grid_wd  = 1'b0;
                cnt_next = cnt_reg + LEN_W'(1);
                if (cnt_reg[CELL_W-1:0] == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_valid) begin
                    r_next     = req;
                    res_next   = '0;
                    state_next = S_DONE;
                    case (req.cmd)
                        CMD_WRITE: begin
                            grid_we         = req.start_ok;
                            res_next.status = req.start_ok ? ST_OK : ST_RANGE;
                        end
                        CMD_FIND: begin
                            slen_next      = '0;
                            scost_next     = '0;
                            heap_req.clear = 1'b1;
                            if (req.start_ok && req.end_ok) begin
                                cnt_next   = '0;
                                state_next = S_CLR;
                            end else begin
                                res_next.status = ST_RANGE;
                            end
                        end
                        CMD_READ: state_next = S_READ;
                        default:  res_next   = '0;
                    endcase
                end
            end
            S_READ: begin
                res_next.len  = slen_reg;
                res_next.cost = scost_reg;
                if (LEN_W'(r_reg.idx) < slen_reg) begin
                    res_next.status = ST_OK;
                    res_next.sx     = path_rd[COORD_W-1:0];
                    res_next.sz     = path_rd[CELL_W-1:COORD_W];
                end else begin
                    res_next.status = ST_BEYOND;
                end
                state_next = S_DONE;
            end
            S_CLR: begin
                node_we  = 1'b1;
                node_wa  = cnt_reg[CELL_W-1:0];
                node_wd  = '0;
                cnt_next = cnt_reg + LEN_W'(1);
                if (cnt_reg[CELL_W-1:0] == '1) begin
                    state_next = S_SEED;
                end
            end
            S_SEED: begin
                node_we       = 1'b1;
                node_wa       = start_cell;
                node_wd       = '0;
                node_wd.seen  = 1'b1;
                heap_req.push = 1'b1;
                heap_req.key  = {F_W'(manhattan(r_reg.x, r_reg.z, r_reg.ex, r_reg.ez)),
                                 start_cell};
                state_next    = S_POP;
            end
            S_POP: begin
                if (heap_sts.idle) begin
                    if (heap_sts.empty) begin
                        res_next.status = ST_NOPATH;
                        state_next      = S_DONE;
                    end else begin
                        heap_req.pop = 1'b1;
                        state_next   = S_POP_WAIT;
                    end
                end
            end
            S_POP_WAIT: begin
                node_ra = heap_sts.top_key[CELL_W-1:0];
                if (heap_sts.idle) begin
                    cur_next   = heap_sts.top_key[CELL_W-1:0];
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (node_rd.closed) begin
                    state_next = S_POP;
                end else begin
                    node_we        = 1'b1;
                    node_wd.closed = 1'b1;
                    gcur_next      = node_rd.g;
                    if (cur_reg == end_cell) begin
                        scost_next = node_rd.g;
                        cnt_next   = '0;
                        state_next = S_TR;
                    end else begin
                        dir_next   = DIR_ZP;
                        state_next = S_NB;
                    end
                end
            end
            S_NB: begin
                if (nb_ok) begin
                    nb_next    = {nz, nx};
                    state_next = S_NB_CHK;
                end else if (dir_reg == DIR_XN) begin
                    state_next = S_POP;
                end else begin
                    dir_next = dir_reg + 2'd1;
                end
            end
            S_NB_CHK: begin
                if (!node_rd.closed && (!node_rd.seen || ng < node_rd.g)) begin
                    node_we       = 1'b1;
                    node_wa       = nb_reg;
                    node_wd       = {1'b1, 1'b0, dir_reg, ng};
                    heap_req.push = 1'b1;
                    state_next    = S_PUSH_WAIT;
                end else if (dir_reg == DIR_XN) begin
                    state_next = S_POP;
                end else begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = S_NB;
                end
            end
            S_PUSH_WAIT: begin
                if (heap_sts.idle) begin
                    if (dir_reg == DIR_XN) begin
                        state_next = S_POP;
                    end else begin
                        dir_next   = dir_reg + 2'd1;
                        state_next = S_NB;
                    end
                end
            end
            S_TR: begin
                // path is stored goal first
                path_we = 1'b1;
                node_ra = cur_reg;
                if (cur_reg == start_cell) begin
                    slen_next       = cnt_reg + LEN_W'(1);
                    res_next.status = ST_OK;
                    res_next.len    = cnt_reg + LEN_W'(1);
                    res_next.cost   = scost_reg;
                    state_next      = S_DONE;
                end else begin
                    state_next = S_TR_RD;
                end
            end
            S_TR_RD: begin
                cur_next   = {pz, px};
                cnt_next   = cnt_reg + LEN_W'(1);
                state_next = S_TR;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            slen_reg  <= '0;
            scost_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            slen_reg  <= slen_next;
            scost_reg <= scost_next;
        end
        r_reg    <= r_next;
        res_reg  <= res_next;
        cur_reg  <= cur_next;
        nb_reg   <= nb_next;
        gcur_reg <= gcur_next;
        dir_reg  <= dir_next;
    end

    always_ff @(posedge aclk) begin
        if (grid_we) begin
            grid_mem[grid_wa] <= grid_wd;
        end
        grid_rd <= grid_mem[grid_ra];
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_wa] <= node_wd;
        end
        node_rd <= node_mem[node_ra];
    end

    always_ff @(posedge aclk) begin
        if (path_we) begin
            path_mem[path_wa] <= cur_reg;
        end
        path_rd <= path_mem[path_ra];
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

>>> hw/rtl/grid_astar_path_search_unit.sv
// ============================================================================
// grid_astar_path_search_unit
// A* path search over a 64x64 grid of cheap and costly cells.
// ============================================================================
//
//  channel  | ports               | contents
//  ---------+---------------------+----------------------------------------
//  request  | s_tvalid/s_tready   | s_tuser: cmd; s_tdata: cell, goal, kind,
//           |                     |   step index
//  result   | m_tvalid/m_tready   | m_tuser: status; s_tdata-like pack of
//           |                     |   length, cost, step cell
//  config   | cfg_wr_en           | cfg_index selects register, cfg_wdata
//
//  A write, a step read or a failed range check is answered without a search. A find
//  first sweeps the node memory, then expands cells and skips stale pops, each push
//  and each pop walking the heap levels, then traces the path back cell by cell.
//  One request is in work at a time; the heap and node memory ports set the pace.
//  Reset clears the grid memory; no request is taken until that is done.
//  A result waits in the output register while the next request is taken.
// ============================================================================
module grid_astar_path_search_unit #(
    parameter int HEAP_DEPTH = gaps_pkg::HEAP_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cell_x[5:0] cell_z[11:6] end_x[17:12] end_z[23:18] cell_kind[25:24]
    // step_index[37:26], zero[39:38]
    input  logic [39:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // path_length[12:0] path_cost[32:13] step_x[38:33] step_z[44:39]
    // zero[47:45]
    output logic [47:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);
    import gaps_pkg::*;

    // configuration registers
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [COST_W-1:0] open_reg, wall_reg;
    logic [DIM_W-1:0]  w_eff, h_eff;

    gaps_req_t      req;
    gaps_res_t      res;
    logic           req_ready, res_valid, res_ready;
    gaps_heap_req_t heap_req;
    gaps_heap_sts_t heap_sts;

    logic      m_valid_reg;
    gaps_res_t m_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
            open_reg   <= COST_W'(1);
            wall_reg   <= COST_W'(100);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_wdata[DIM_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_wdata[DIM_W-1:0];
                CFG_OPEN:   open_reg   <= cfg_wdata;
                CFG_WALL:   wall_reg   <= cfg_wdata;
                default:    open_reg   <= open_reg;
            endcase
        end
    end

    // zero counts as one, above the maximum counts as the maximum
    always_comb begin
        w_eff = width_reg;
        if (width_reg == '0) begin
            w_eff = DIM_W'(1);
        end else if (width_reg > DIM_W'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        h_eff = height_reg;
        if (height_reg == '0) begin
            h_eff = DIM_W'(1);
        end else if (height_reg > DIM_W'(MAX_HEIGHT)) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end
    end

    // unpack the request and do the range checks up front
    always_comb begin
        req.cmd       = s_tuser;
        req.x         = s_tdata[5:0];
        req.z         = s_tdata[11:6];
        req.ex        = s_tdata[17:12];
        req.ez        = s_tdata[23:18];
        req.kind      = s_tdata[25:24];
        req.idx       = s_tdata[37:26];
        req.start_ok  = (DIM_W'(s_tdata[5:0]) < w_eff) && (DIM_W'(s_tdata[11:6]) < h_eff);
        req.end_ok    = (DIM_W'(s_tdata[17:12]) < w_eff) && (DIM_W'(s_tdata[23:18]) < h_eff);
        req.w         = w_eff;
        req.h         = h_eff;
        req.open_cost = open_reg;
        req.wall_cost = wall_reg;
    end

    gaps_search u_search (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .req_valid (s_tvalid),
        .req_ready (req_ready),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .heap_req  (heap_req),
        .heap_sts  (heap_sts)
    );

    gaps_heap #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_heap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (heap_req),
        .sts     (heap_sts)
    );

    assign s_tready  = req_ready;

    // output register, refilled when empty or being drained
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {3'b000, m_res_reg.sz, m_res_reg.sx, m_res_reg.cost, m_res_reg.len};

`ifndef SYNTH
    // one request at a time: taking a request leaves the sequencer busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while search busy");

    // a failed search reports no stored path
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_NOPATH || m_tuser == ST_RANGE)) |->
        (m_tdata[12:0] == '0 && m_tdata[32:13] == '0))
        else $error("failed result carries a path");

    // a stored path never holds more cells than the grid
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[12:0] <= 13'(CELLS)))
        else $error("path length beyond grid size");
`endif

endmodule
